[rtl/core/bqdf2_pkg.sv]
// Shared constants, types and rounding and saturation helpers of the direct form II biquad section.
package bqdf2_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 32;
  localparam int STATE_BITS   = 32;
  localparam int COEF_FRAC    = COEF_BITS - 2;
  localparam int PROD_BITS    = COEF_BITS + STATE_BITS;
  localparam int ACC_BITS     = PROD_BITS + 3;
  localparam int RND_BITS     = ACC_BITS - COEF_FRAC;
  localparam int CFG_IDX_BITS = 3;
  localparam int SAMPLE_BYTES = (SAMPLE_BITS + 7) / 8;
  localparam int SAMPLE_TDATA = SAMPLE_BYTES * 8;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FB1,
    ST_FB2,
    ST_FBSUM,
    ST_WRND,
    ST_FF1,
    ST_FF2,
    ST_FFSUM,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_A1D1,
    MUL_A2D2,
    MUL_B1D1,
    MUL_B2D2,
    MUL_B0W
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB,
    ACC_ADD,
    ACC_CLEAR
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     w_load;
    logic     y_load;
  } ctrl_t;

  // Adds half an LSB and drops the coefficient fraction bits.
  function automatic logic signed [RND_BITS-1:0] round_half_up(
    input logic signed [ACC_BITS-1:0] acc
  );
    logic signed [ACC_BITS-1:0] sum;
    sum = acc + (ACC_BITS'(1) << (COEF_FRAC - 1));
    return sum[ACC_BITS-1:COEF_FRAC];
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [RND_BITS-1:0] r
  );
    logic [RND_BITS-STATE_BITS:0] top;
    top = r[RND_BITS-1:STATE_BITS-1];
    if (top == '0 || top == '1) begin
      return r[STATE_BITS-1:0];
    end else if (r[RND_BITS-1]) begin
      return {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [RND_BITS-1:0] r
  );
    logic [RND_BITS-SAMPLE_BITS:0] top;
    top = r[RND_BITS-1:SAMPLE_BITS-1];
    if (top == '0 || top == '1) begin
      return r[SAMPLE_BITS-1:0];
    end else if (r[RND_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

[rtl/core/biquad_direct_form_two_filter.sv]
// Direct form II biquad section built around one shared multiplier and accumulator.
//
// The input channel takes one request per item: in_tuser[0] is the command
// (0 filters the sample in in_tdata, 1 clears both delay words) and in_tdata
// holds the signed Q1.23 sample. The output channel carries the filtered
// sample, saturated to Q1.23, in out_tdata.
// A filter request occupies the block from acceptance until the result is
// loaded into the output register: five products pass one at a time through
// the single 32 by 32 multiplier, and two rounding steps follow the feedback
// and feed-forward sums. in_tready is low during that time, so the block takes
// no new sample until the result of the last one is loaded.
// A clear request produces no result and leaves the block ready for the next request.
// The result register is separate from the sequencer, so a new request is
// accepted while an earlier result still waits. If the receiver stalls, the
// sequencer holds in its final step until the result register is free.
// The user writes cfg coefficients only while the block is idle; it is not enforced.
// Reset brings the coefficients to a bypass (b0 = 1.0, others zero), clears
// the delay words and leaves the output channel empty.
module biquad_direct_form_two_filter
  import bqdf2_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [SAMPLE_TDATA-1:0] in_tdata,   // [23:0] sample_in
  input  logic [0:0]              in_tuser,   // [0] command
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [SAMPLE_TDATA-1:0] out_tdata,  // [23:0] sample_out
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_wdata
);

  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  logic signed [COEF_BITS-1:0]   b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [STATE_BITS-1:0]  d1_r, d2_r, w_r;
  logic signed [SAMPLE_BITS-1:0] x_r, y_r;
  logic signed [ACC_BITS-1:0]    acc_r, acc_nxt, x_ext;
  logic signed [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic signed [COEF_BITS-1:0]   op_c;
  logic signed [STATE_BITS-1:0]  op_d;
  logic signed [RND_BITS-1:0]    rnd;
  logic                          out_valid_r;
  logic                          in_fire, out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = SAMPLE_TDATA'(unsigned'(y_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && !in_tuser[0]) state_nxt = ST_FB1;
      ST_FB1:   state_nxt = ST_FB2;
      ST_FB2:   state_nxt = ST_FBSUM;
      ST_FBSUM: state_nxt = ST_WRND;
      ST_WRND:  state_nxt = ST_FF1;
      ST_FF1:   state_nxt = ST_FF2;
      ST_FF2:   state_nxt = ST_FFSUM;
      ST_FFSUM: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '{mul_sel: MUL_A1D1, acc_op: ACC_HOLD, w_load: 1'b0, y_load: 1'b0};
    unique case (state_r)
      ST_IDLE:  ;
      ST_FB1:   ctrl.acc_op = ACC_LOAD_X;
      ST_FB2: begin
        ctrl.mul_sel = MUL_A2D2;
        ctrl.acc_op  = ACC_SUB;
      end
      ST_FBSUM: ctrl.acc_op = ACC_SUB;
      ST_WRND: begin
        ctrl.mul_sel = MUL_B1D1;
        ctrl.acc_op  = ACC_CLEAR;
        ctrl.w_load  = 1'b1;
      end
      ST_FF1: begin
        ctrl.mul_sel = MUL_B2D2;
        ctrl.acc_op  = ACC_ADD;
      end
      ST_FF2: begin
        ctrl.mul_sel = MUL_B0W;
        ctrl.acc_op  = ACC_ADD;
      end
      ST_FFSUM: ctrl.acc_op = ACC_ADD;
      ST_OUT:   ctrl.y_load = out_free;
      default:  ;
    endcase
  end

  always_comb begin
    case (ctrl.mul_sel)
      MUL_A1D1: begin op_c = a1_r; op_d = d1_r; end
      MUL_A2D2: begin op_c = a2_r; op_d = d2_r; end
      MUL_B1D1: begin op_c = b1_r; op_d = d1_r; end
      MUL_B2D2: begin op_c = b2_r; op_d = d2_r; end
      MUL_B0W:  begin op_c = b0_r; op_d = w_r;  end
      default:  begin op_c = a1_r; op_d = d1_r; end
    endcase
    prod_nxt = op_c * op_d;
  end

  assign x_ext = $signed({{(ACC_BITS-SAMPLE_BITS-COEF_FRAC){x_r[SAMPLE_BITS-1]}},
                          x_r, {COEF_FRAC{1'b0}}});
  assign rnd   = round_half_up(acc_r);

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD_X: acc_nxt = x_ext;
      ACC_SUB:    acc_nxt = acc_r - ACC_BITS'(prod_r);
      ACC_ADD:    acc_nxt = acc_r + ACC_BITS'(prod_r);
      ACC_CLEAR:  acc_nxt = '0;
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      b0_r        <= COEF_ONE;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      d1_r        <= '0;
      d2_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.y_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_B0:  b0_r <= cfg_wdata;
          REG_B1:  b1_r <= cfg_wdata;
          REG_B2:  b2_r <= cfg_wdata;
          REG_A1:  a1_r <= cfg_wdata;
          REG_A2:  a2_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire && in_tuser[0]) begin
        d1_r <= '0;
        d2_r <= '0;
      end else if (ctrl.y_load) begin
        d2_r <= d1_r;
        d1_r <= w_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (in_fire) begin
      x_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (ctrl.w_load) begin
      w_r <= sat_state(rnd);
    end
    if (ctrl.y_load) begin
      y_r <= sat_sample(rnd);
    end
  end

endmodule

[rtl/core/bqdf2_checker.sv]
// Port-level checks of the biquad section and their binding to the top level.
module bqdf2_checker
  import bqdf2_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_tvalid,
  input logic                    in_tready,
  input logic [0:0]              in_tuser,
  input logic                    out_tvalid,
  input logic                    out_tready,
  input logic [SAMPLE_TDATA-1:0] out_tdata
);

  // The output channel is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result presented straight after reset");

  // A filter request keeps the sequencer busy in the next cycle.
  a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> !in_tready)
    else $error("filter request did not occupy the block");

  // A clear request leaves the block ready again in the next cycle.
  a_clear_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> in_tready)
    else $error("clear request kept the block busy");

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

endmodule

bind biquad_direct_form_two_filter bqdf2_checker u_bqdf2_checker (.*);

[dv/tb_biquad_direct_form_two_filter.sv]
// Self-checking testbench for the direct form II biquad section with a bit-exact predictor.
`timescale 1ns / 100ps

module tb_biquad_direct_form_two_filter;
  import bqdf2_pkg::*;

  localparam int ACC_W           = 80;
  localparam int NUM_COEFS       = int'(REG_A2) + 1;
  localparam int REG_STRAY_LO    = NUM_COEFS;
  localparam int REG_STRAY_HI    = (1 << CFG_IDX_BITS) - 1;
  localparam int IDLE_PCT        = 8;
  localparam int SETTLE_CYCLES   = 16;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int PLAN_ROWS       = 25;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (COEF_FRAC - 1);

  typedef struct packed {
    logic [1:0]             coef_set;
    logic                   command;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   typed;
    logic [SAMPLE_BITS-1:0] result;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [SAMPLE_TDATA-1:0] in_tdata = '0;
  logic [0:0]              in_tuser = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [SAMPLE_TDATA-1:0] out_tdata;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COEF_BITS-1:0]    cfg_wdata = '0;

  logic signed [COEF_BITS-1:0]   coef_model [NUM_COEFS];
  logic [COEF_BITS-1:0]          next_coefs [NUM_COEFS];
  logic signed [STATE_BITS-1:0]  hist_w1 = '0;
  logic signed [STATE_BITS-1:0]  hist_w2 = '0;
  logic signed [SAMPLE_BITS-1:0] expected_out_q [$];

  logic no_gaps = 1'b0;
  int   cycle_count = 0;
  int   n_filtered = 0;
  int   n_cleared = 0;
  int   n_checked = 0;
  int   n_errors = 0;
  int   n_settings = 0;

  logic [COEF_BITS-1:0] coef_sets [4][NUM_COEFS] = '{
    '{32'h40000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
    '{32'h7FFFFFFF, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
    '{32'h80000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000}
  };

  // Set 0 is the bypass left by reset, sets 1 and 2 drive the output into its limits,
  // set 3 pushes the feedback path into internal saturation.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{2'd0, CMD_FILTER, 24'h000000, 1'b1, 24'h000000},
    '{2'd0, CMD_FILTER, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{2'd0, CMD_FILTER, 24'h800000, 1'b1, 24'h800000},
    '{2'd0, CMD_FILTER, 24'h000001, 1'b1, 24'h000001},
    '{2'd0, CMD_FILTER, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{2'd0, CMD_FILTER, 24'h555555, 1'b1, 24'h555555},
    '{2'd0, CMD_FILTER, 24'hAAAAAA, 1'b1, 24'hAAAAAA},
    '{2'd0, CMD_CLEAR,  24'h123456, 1'b0, 24'h000000},
    '{2'd0, CMD_FILTER, 24'h123456, 1'b1, 24'h123456},
    '{2'd0, CMD_CLEAR,  24'hFFFFFF, 1'b0, 24'h000000},
    '{2'd0, CMD_CLEAR,  24'h000000, 1'b0, 24'h000000},
    '{2'd1, CMD_FILTER, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{2'd1, CMD_FILTER, 24'h800000, 1'b1, 24'h800000},
    '{2'd1, CMD_FILTER, 24'h000001, 1'b1, 24'h000002},
    '{2'd1, CMD_FILTER, 24'hFFFFFF, 1'b1, 24'hFFFFFE},
    '{2'd1, CMD_FILTER, 24'h000000, 1'b1, 24'h000000},
    '{2'd2, CMD_FILTER, 24'h7FFFFF, 1'b1, 24'h800000},
    '{2'd2, CMD_FILTER, 24'h800000, 1'b1, 24'h7FFFFF},
    '{2'd2, CMD_FILTER, 24'h000001, 1'b1, 24'hFFFFFE},
    '{2'd3, CMD_FILTER, 24'h7FFFFF, 1'b0, 24'h000000},
    '{2'd3, CMD_FILTER, 24'h7FFFFF, 1'b0, 24'h000000},
    '{2'd3, CMD_FILTER, 24'h7FFFFF, 1'b0, 24'h000000},
    '{2'd3, CMD_CLEAR,  24'h000000, 1'b0, 24'h000000},
    '{2'd3, CMD_FILTER, 24'h800000, 1'b0, 24'h000000},
    '{2'd3, CMD_FILTER, 24'h800000, 1'b0, 24'h000000}
  };

  biquad_direct_form_two_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [23:0] sample_in
    .in_tuser  (in_tuser),    // [0] command
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [23:0] sample_out
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [ACC_W-1:0] round_clip(
    input logic signed [ACC_W-1:0] sum,
    input int                      bits
  );
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] top;
    logic signed [ACC_W-1:0] bottom;
    r = (sum + HALF_LSB) >>> COEF_FRAC;
    top = (ACC_W'(1) << (bits - 1)) - 1;
    bottom = -top - 1;
    if (r > top) begin
      return top;
    end else if (r < bottom) begin
      return bottom;
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
    input logic signed [SAMPLE_BITS-1:0] x
  );
    logic signed [ACC_W-1:0] xs;
    logic signed [ACC_W-1:0] d1;
    logic signed [ACC_W-1:0] d2;
    logic signed [ACC_W-1:0] w;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
    xs = x;
    d1 = hist_w1;
    d2 = hist_w2;
    acc = (xs <<< COEF_FRAC) - coef_model[REG_A1] * d1 - coef_model[REG_A2] * d2;
    w = round_clip(acc, STATE_BITS);
    acc = coef_model[REG_B0] * w + coef_model[REG_B1] * d1 + coef_model[REG_B2] * d2;
    y = round_clip(acc, SAMPLE_BITS);
    hist_w2 = hist_w1;
    hist_w1 = w[STATE_BITS-1:0];
    return y[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    logic [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0: s = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      1: s = SAMPLE_BITS'($urandom_range(0, 15)) - SAMPLE_BITS'(8);
      default: s = SAMPLE_BITS'($urandom());
    endcase
    return s;
  endfunction

  task automatic send_request(
    input logic                   cmd,
    input logic [SAMPLE_BITS-1:0] smp,
    input logic                   typed,
    input logic [SAMPLE_BITS-1:0] typed_y
  );
    logic signed [SAMPLE_BITS-1:0] predicted;
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_CLEAR) begin
      hist_w1 = '0;
      hist_w2 = '0;
      n_cleared++;
    end else begin
      predicted = filter_sample(smp);
      expected_out_q.push_back(typed ? typed_y : predicted);
      n_filtered++;
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_coefs();
    logic [CFG_IDX_BITS-1:0] stray;
    stray = CFG_IDX_BITS'($urandom_range(REG_STRAY_LO, REG_STRAY_HI));
    for (int i = 0; i < NUM_COEFS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(i);
      cfg_wdata <= next_coefs[i];
      coef_model[i] = next_coefs[i];
      @(posedge clk);
    end
    // Writes beyond the last coefficient must leave every register untouched.
    cfg_we <= 1'b1;
    cfg_index <= stray;
    cfg_wdata <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  function automatic logic [COEF_BITS-1:0] mild_coef(input logic [COEF_BITS-1:0] r);
    return {{3{r[28]}}, r[28:0]};
  endfunction

  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_out_q.size() == 0) begin
        $display("%0t: result with none pending, expected none, actual %0d", $time,
                 $signed(out_tdata[SAMPLE_BITS-1:0]));
        n_errors++;
      end else begin
        want = expected_out_q.pop_front();
        n_checked++;
        if (out_tdata[SAMPLE_BITS-1:0] !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want,
                   $signed(out_tdata[SAMPLE_BITS-1:0]));
          n_errors++;
        end
      end
    end
  end

  initial begin
    logic [1:0] active_set;
    logic [31:0] r;
    logic        cmd;
    foreach (coef_model[k]) begin
      coef_model[k] = coef_sets[0][k];
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    active_set = 2'd0;
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (directed_plan[i].coef_set != active_set) begin
        active_set = directed_plan[i].coef_set;
        wait_idle();
        next_coefs = coef_sets[active_set];
        load_coefs();
      end
      send_request(directed_plan[i].command, directed_plan[i].sample,
                   directed_plan[i].typed, directed_plan[i].result);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      for (int k = 0; k < NUM_COEFS; k++) begin
        r = $urandom();
        case (p)
          1: next_coefs[k] = 32'h7FFFFFFF;
          2: next_coefs[k] = 32'h80000000;
          3, 5: next_coefs[k] = r;
          default: next_coefs[k] = mild_coef(r);
        endcase
      end
      if (p == 0 || p == 4 || p == 6) begin
        next_coefs[REG_A2] = {3'b000, next_coefs[REG_A2][28:0]};
      end
      load_coefs();
      no_gaps <= (p == 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        cmd = ($urandom_range(0, 9) == 0) ? CMD_CLEAR : CMD_FILTER;
        send_request(cmd, random_sample(), 1'b0, '0);
      end
    end

    wait_idle();
    $display("Covered %0d filtered samples and %0d delay clears across %0d coefficient loads.",
             n_filtered, n_cleared, n_settings);
    $display("Compared %0d output samples, %0d of them wrong or unexpected.",
             n_checked, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
